/* rtl/core/gtp_u_header_validator_defines.svh */
// Assertion macros for the GTP-U header validator.
// Both macros sample on the rising edge of clock and are disabled during reset.
// Defining NO_ASSERTIONS removes every assertion.
`ifndef GTP_U_HEADER_VALIDATOR_DEFINES_SVH
`define GTP_U_HEADER_VALIDATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define GTPUHV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define GTPUHV_ASSERT_NEVER(label, expr, msg) \
   `GTPUHV_ASSERT(label, !(expr), msg)

`else

`define GTPUHV_ASSERT(label, prop, msg)

`define GTPUHV_ASSERT_NEVER(label, expr, msg)

`endif

`endif

/* rtl/core/gtpuhv_pkg.sv */
package gtpuhv_pkg;

   localparam int MaxPacketBytesDefault = 65535;

   // Fixed header layout
   localparam logic [15:0] HdrBytes       = 16'd8;
   localparam logic [7:0]  FlagCheckMask  = 8'hf0;
   localparam logic [7:0]  FlagCheckValue = 8'h30;
   localparam logic [7:0]  OptPresentMask = 8'h07;
   localparam logic [7:0]  TypeTpdu       = 8'hff;
   localparam logic [15:0] OptBytes       = 16'd4;

   // Verdict codes
   localparam logic [2:0] StatusOk       = 3'd0;
   localparam logic [2:0] StatusShort    = 3'd1;
   localparam logic [2:0] StatusBadFlags = 3'd2;
   localparam logic [2:0] StatusBadType  = 3'd3;
   localparam logic [2:0] StatusShortMsg = 3'd4;
   localparam logic [2:0] StatusBadExt   = 3'd5;
   localparam logic [2:0] StatusBadIpVer = 3'd6;
   localparam logic [2:0] StatusTooLong  = 3'd7;

   localparam logic [3:0] IpVersion4 = 4'd4;
   localparam logic [3:0] IpVersion6 = 4'd6;

   // Header walk phases
   localparam logic [2:0] PhHeader = 3'd0;
   localparam logic [2:0] PhType   = 3'd1;
   localparam logic [2:0] PhLen    = 3'd2;
   localparam logic [2:0] PhDone   = 3'd3;
   localparam logic [2:0] PhStop   = 3'd4;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] tunnel_id;
      logic [15:0] payload_offset;
      logic [15:0] payload_length;
      logic [3:0]  ip_version;
   } result_type;

endpackage

/* rtl/core/gtpuhv_req_if.sv */
interface gtpuhv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/core/gtpuhv_rsp_if.sv */
interface gtpuhv_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] tunnel_id;
   logic [15:0] payload_offset;
   logic [15:0] payload_length;
   logic [3:0]  ip_version;

   modport source (output valid, output status, output tunnel_id, output payload_offset,
                   output payload_length, output ip_version, input ready);
   modport sink (input valid, input status, input tunnel_id, input payload_offset,
                 input payload_length, input ip_version, output ready);
endinterface

/* rtl/core/gtp_u_header_validator.sv */
// Verdicts are registered in the result register, or in the skid entry when it stalls.
// Throughput: one byte per cycle, back to back, across packet boundaries.
// A two-entry output stage (result register plus skid) holds verdicts; input stalls
// only while both entries are full.
// Reset: synchronous, active high; clears the parse state and empties the output stage.
`include "gtp_u_header_validator_defines.svh"

module gtp_u_header_validator #(
   parameter int MAX_PACKET_BYTES = gtpuhv_pkg::MaxPacketBytesDefault
) (
   input logic         clock,
   input logic         reset,
   gtpuhv_req_if.sink   req_bus,
   gtpuhv_rsp_if.source rsp_bus
);
   import gtpuhv_pkg::*;

   localparam logic [15:0] MaxBytes = 16'(MAX_PACKET_BYTES);

   // Parse state
   logic [15:0] byte_index_ff, byte_index_in;
   logic [7:0]  flag_bits_ff, flag_bits_in;
   logic [7:0]  message_type_ff, message_type_in;
   logic [15:0] declared_length_ff, declared_length_in;
   logic [31:0] teid_ff, teid_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] next_pos_ff, next_pos_in;
   logic [2:0]  error_ff, error_in;
   logic [3:0]  inner_version_ff, inner_version_in;
   logic [2:0]  phase_ff, phase_in;
   logic [15:0] payload_pos_ff, payload_pos_in;
   logic        too_long_ff, too_long_in;
   logic        have_version_ff, have_version_in;

   // Values after this byte, before the end-of-packet clear
   logic [15:0] byte_index_step;
   logic [7:0]  flag_bits_step;
   logic [7:0]  message_type_step;
   logic [15:0] declared_length_step;
   logic [31:0] teid_step;
   logic [15:0] remaining_step;
   logic [15:0] next_pos_step;
   logic [2:0]  error_step;
   logic [3:0]  inner_version_step;
   logic [2:0]  phase_step;
   logic [15:0] payload_pos_step;
   logic        too_long_step;
   logic        have_version_step;

   logic [7:0]  b;
   logic [15:0] i;
   logic [15:0] ext_len;
   logic [16:0] ext_end;
   logic [16:0] msg_end;
   result_type  result;

   // Output stage
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   logic accept;
   logic verdict;
   logic rsp_take;

   assign req_bus.ready = !skid_valid_ff;
   assign accept        = req_bus.valid && req_bus.ready;
   assign verdict       = accept && req_bus.last_byte;
   assign rsp_take      = rsp_valid_ff && rsp_bus.ready;

   assign b       = req_bus.data_byte;
   assign i       = byte_index_ff;
   assign ext_len = {6'd0, b, 2'b00};
   assign ext_end = {1'b0, i} + {1'b0, ext_len} - 17'd1;

   always_comb begin
      flag_bits_step       = flag_bits_ff;
      message_type_step    = message_type_ff;
      declared_length_step = declared_length_ff;
      teid_step            = teid_ff;
      remaining_step       = remaining_ff;
      next_pos_step        = next_pos_ff;
      error_step           = error_ff;
      inner_version_step   = inner_version_ff;
      phase_step           = phase_ff;
      payload_pos_step     = payload_pos_ff;
      have_version_step    = have_version_ff;

      too_long_step   = too_long_ff || (byte_index_ff >= MaxBytes);
      byte_index_step = (byte_index_ff == 16'hffff) ? byte_index_ff
                                                     : byte_index_ff + 16'd1;

      if (!too_long_step) begin
         if (i < HdrBytes) begin
            case (i[2:0])
               3'd0: flag_bits_step = b;
               3'd1: message_type_step = b;
               3'd2: declared_length_step = {b, declared_length_ff[7:0]};
               3'd3: declared_length_step = {declared_length_ff[15:8], b};
               default: teid_step = {teid_ff[23:0], b};
            endcase
            if (i == HdrBytes - 16'd1) begin
               if ((flag_bits_ff & OptPresentMask) != 8'd0) begin
                  if (declared_length_ff < OptBytes) begin
                     remaining_step = declared_length_ff;
                     error_step     = StatusShortMsg;
                     phase_step     = PhStop;
                  end else begin
                     // sequence number, N-PDU number, then the first next-type octet
                     remaining_step = declared_length_ff - OptBytes;
                     next_pos_step  = HdrBytes + 16'd3;
                     phase_step     = PhType;
                  end
               end else begin
                  remaining_step   = declared_length_ff;
                  payload_pos_step = HdrBytes;
                  phase_step       = PhDone;
               end
            end
         end else if (phase_ff == PhType && i == next_pos_ff) begin
            if (b == 8'd0) begin
               payload_pos_step = i + 16'd1;
               phase_step       = PhDone;
            end else if (remaining_ff == 16'd0) begin
               error_step = StatusShortMsg;
               phase_step = PhStop;
            end else begin
               next_pos_step = i + 16'd1;
               phase_step    = PhLen;
            end
         end else if (phase_ff == PhLen && i == next_pos_ff) begin
            if (b == 8'd0) begin
               error_step = StatusBadExt;
               phase_step = PhStop;
            end else if (remaining_ff < ext_len) begin
               error_step = StatusShortMsg;
               phase_step = PhStop;
            end else begin
               remaining_step = remaining_ff - ext_len;
               next_pos_step  = ext_end[16] ? 16'hffff : ext_end[15:0];
               phase_step     = PhType;
            end
         end else if (phase_ff == PhDone && i == payload_pos_ff && remaining_ff != 16'd0) begin
            inner_version_step = b[7:4];
            have_version_step  = 1'b1;
         end
      end
   end

   assign msg_end = {1'b0, HdrBytes} + {1'b0, declared_length_step};

   always_comb begin
      result = '0;
      if (too_long_step) begin
         result.status = StatusTooLong;
      end else if (byte_index_step < HdrBytes) begin
         result.status = StatusShort;
      end else begin
         result.tunnel_id = teid_step;
         if ((flag_bits_step & FlagCheckMask) != FlagCheckValue) begin
            result.status = StatusBadFlags;
         end else if (message_type_step != TypeTpdu) begin
            result.status = StatusBadType;
         end else if (msg_end > {1'b0, byte_index_step}) begin
            result.status = StatusShortMsg;
         end else if (error_step != StatusOk) begin
            result.status = error_step;
         end else if (phase_step != PhDone) begin
            result.status = StatusShortMsg;
         end else begin
            result.payload_offset = payload_pos_step;
            result.payload_length = remaining_step;
            result.ip_version     = have_version_step ? inner_version_step : 4'd0;
            if (!have_version_step ||
                (inner_version_step != IpVersion4 && inner_version_step != IpVersion6)) begin
               result.status = StatusBadIpVer;
            end
         end
      end
   end

   // Next state: hold when idle, step on a byte, clear after the verdict
   always_comb begin
      byte_index_in      = byte_index_ff;
      flag_bits_in       = flag_bits_ff;
      message_type_in    = message_type_ff;
      declared_length_in = declared_length_ff;
      teid_in            = teid_ff;
      remaining_in       = remaining_ff;
      next_pos_in        = next_pos_ff;
      error_in           = error_ff;
      inner_version_in   = inner_version_ff;
      phase_in           = phase_ff;
      payload_pos_in     = payload_pos_ff;
      too_long_in        = too_long_ff;
      have_version_in    = have_version_ff;
      if (verdict) begin
         byte_index_in      = '0;
         flag_bits_in       = '0;
         message_type_in    = '0;
         declared_length_in = '0;
         teid_in            = '0;
         remaining_in       = '0;
         next_pos_in        = '0;
         error_in           = StatusOk;
         inner_version_in   = '0;
         phase_in           = PhHeader;
         payload_pos_in     = '0;
         too_long_in        = 1'b0;
         have_version_in    = 1'b0;
      end else if (accept) begin
         byte_index_in      = byte_index_step;
         flag_bits_in       = flag_bits_step;
         message_type_in    = message_type_step;
         declared_length_in = declared_length_step;
         teid_in            = teid_step;
         remaining_in       = remaining_step;
         next_pos_in        = next_pos_step;
         error_in           = error_step;
         inner_version_in   = inner_version_step;
         phase_in           = phase_step;
         payload_pos_in     = payload_pos_step;
         too_long_in        = too_long_step;
         have_version_in    = have_version_step;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (rsp_take || !rsp_valid_ff) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = verdict;
            rsp_in       = result;
         end
      end else if (verdict) begin
         // result register is stalled: park the verdict in the skid entry
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff      <= '0;
         flag_bits_ff       <= '0;
         message_type_ff    <= '0;
         declared_length_ff <= '0;
         teid_ff            <= '0;
         remaining_ff       <= '0;
         next_pos_ff        <= '0;
         error_ff           <= StatusOk;
         inner_version_ff   <= '0;
         phase_ff           <= PhHeader;
         payload_pos_ff     <= '0;
         too_long_ff        <= 1'b0;
         have_version_ff    <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         skid_valid_ff      <= 1'b0;
      end else begin
         byte_index_ff      <= byte_index_in;
         flag_bits_ff       <= flag_bits_in;
         message_type_ff    <= message_type_in;
         declared_length_ff <= declared_length_in;
         teid_ff            <= teid_in;
         remaining_ff       <= remaining_in;
         next_pos_ff        <= next_pos_in;
         error_ff           <= error_in;
         inner_version_ff   <= inner_version_in;
         phase_ff           <= phase_in;
         payload_pos_ff     <= payload_pos_in;
         too_long_ff        <= too_long_in;
         have_version_ff    <= have_version_in;
         rsp_valid_ff       <= rsp_valid_in;
         skid_valid_ff      <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_ff.status;
   assign rsp_bus.tunnel_id      = rsp_ff.tunnel_id;
   assign rsp_bus.payload_offset = rsp_ff.payload_offset;
   assign rsp_bus.payload_length = rsp_ff.payload_length;
   assign rsp_bus.ip_version     = rsp_ff.ip_version;

   `GTPUHV_ASSERT_NEVER(a_skid_without_main, skid_valid_ff && !rsp_valid_ff, "skid entry full while result register empty")
   `GTPUHV_ASSERT(a_state_cleared_after_verdict, verdict |=> (byte_index_ff == 16'd0 && phase_ff == PhHeader), "parse state not cleared after last byte")
   `GTPUHV_ASSERT(a_ok_has_ip_version, (rsp_valid_ff && rsp_ff.status == StatusOk) |-> (rsp_ff.ip_version == IpVersion4 || rsp_ff.ip_version == IpVersion6), "ok verdict without IPv4 or IPv6 payload")
   `GTPUHV_ASSERT(a_short_fields_zero, (rsp_valid_ff && (rsp_ff.status == StatusShort || rsp_ff.status == StatusTooLong)) |-> (rsp_ff.tunnel_id == 32'd0 && rsp_ff.payload_length == 16'd0), "short or too-long verdict carries header fields")

endmodule
